// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the injector RTL.
// No dependencies; define SYNTHESIS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BLCI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("blci assertion failed");

`define BLCI_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("blci forbidden condition seen");

`else

`define BLCI_ASSERT(label, clk, rst, prop)

`define BLCI_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- rtl/blci_pkg.sv -----
// Shared widths, reset values, register indexes and controller/datapath structs
// for the burst loss channel injector. No dependencies.
package blci_pkg;

   localparam int LEN_WIDTH        = 10;
   localparam int BLOCK_SIZE       = 512;
   localparam int REM_WIDTH        = $clog2(BLOCK_SIZE + 1);
   localparam int CNT_WIDTH        = (LEN_WIDTH > REM_WIDTH) ? LEN_WIDTH : REM_WIDTH;
   localparam int CMP_WIDTH        = CNT_WIDTH + 1;
   localparam int WORD_WIDTH       = 32;
   localparam int MARK_MOD_WIDTH   = 8;
   localparam int MOD_WIDTH        = 16;
   localparam int CSR_INDEX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic [MARK_MOD_WIDTH-1:0] GOOD_MOD_RESET = 8'd6;
   localparam logic [MARK_MOD_WIDTH-1:0] BAD_MOD_RESET  = 8'd3;
   localparam logic [MOD_WIDTH-1:0]      FLIP_MOD_RESET = 16'd128;
   localparam logic [WORD_WIDTH-1:0]     SEED_RESET     = 32'd1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GOOD_MODULUS = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAD_MODULUS  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLIP_MODULUS = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRNG_SEED    = 8'd3;

   localparam logic KIND_FLIP = 1'b0;
   localparam logic KIND_MARK = 1'b1;

   typedef struct packed {
      logic capture;
      logic fail;
      logic consume;
      logic split;
      logic start_rem;
      logic start_len;
      logic start_mark;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic len_gt_rem;
      logic rem_zero;
      logic block_good;
      logic ok;
      logic busy;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/blci_modpipe.sv -----
// Pipelined remainder unit: one dividend bit per stage, zero-remainder flag out.
// Depends on blci_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blci_modpipe (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [blci_pkg::WORD_WIDTH-1:0] in_dividend,
   input  logic [blci_pkg::MOD_WIDTH-1:0]  divisor,
   output logic                           out_valid,
   output logic                           out_zero,
   output logic                           busy
);

   localparam int STAGES = blci_pkg::WORD_WIDTH;
   localparam int MW     = blci_pkg::MOD_WIDTH;
   localparam int WW     = blci_pkg::WORD_WIDTH;

   logic [MW-1:0]     rem_ff  [STAGES];
   logic [MW-1:0]     rem_in  [STAGES];
   logic [WW-1:0]     dvd_ff  [STAGES];
   logic [WW-1:0]     dvd_in  [STAGES];
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;

   logic [MW-1:0]     src_rem [STAGES];
   logic [WW-1:0]     src_dvd [STAGES];
   logic [STAGES-1:0] src_vld;
   logic [MW:0]       trial   [STAGES];

   always_comb begin
      src_rem[0] = '0;
      src_dvd[0] = in_dividend;
      src_vld[0] = in_valid;
      for (int k = 1; k < STAGES; k++) begin
         src_rem[k] = rem_ff[k-1];
         src_dvd[k] = dvd_ff[k-1];
         src_vld[k] = vld_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         trial[k] = {src_rem[k], src_dvd[k][WW-1]};
         if (trial[k] >= {1'b0, divisor}) begin
            rem_in[k] = MW'(trial[k] - {1'b0, divisor});
         end else begin
            rem_in[k] = MW'(trial[k]);
         end
         dvd_in[k] = src_dvd[k] << 1;
         vld_in[k] = src_vld[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         rem_ff[k] <= rem_in[k];
         dvd_ff[k] <= dvd_in[k];
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_zero  = (rem_ff[STAGES-1] == '0);
   assign busy      = |vld_ff;

   `BLCI_ASSERT(a_rem_below_divisor, clock, reset, out_valid |-> (rem_ff[STAGES-1] < divisor))

endmodule

// ----- rtl/blci_datapath.sv -----
// Injector datapath: config registers, xorshift generator, block and byte state,
// draw issue counter, remainder pipeline and response register.
// Depends on blci_pkg, blci_modpipe and assert_macros.svh.
`include "assert_macros.svh"

module blci_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [blci_pkg::LEN_WIDTH-1:0]       req_packet_length,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [blci_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [blci_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  blci_pkg::cmd_type                   cmd,
   output blci_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_delivered,
   output logic [blci_pkg::WORD_WIDTH-1:0]      rsp_bad_block_count
);

   localparam int LW  = blci_pkg::LEN_WIDTH;
   localparam int RW  = blci_pkg::REM_WIDTH;
   localparam int CW  = blci_pkg::CNT_WIDTH;
   localparam int PW  = blci_pkg::CMP_WIDTH;
   localparam int WW  = blci_pkg::WORD_WIDTH;
   localparam int MW  = blci_pkg::MOD_WIDTH;
   localparam int GW  = blci_pkg::MARK_MOD_WIDTH;

   function automatic logic [WW-1:0] xorshift(input logic [WW-1:0] x);
      logic [WW-1:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

   logic [GW-1:0] good_mod_ff, good_mod_in;
   logic [GW-1:0] bad_mod_ff, bad_mod_in;
   logic [MW-1:0] flip_mod_ff, flip_mod_in;
   logic [WW-1:0] random_ff, random_in;
   logic [LW-1:0] len_ff, len_in;
   logic [RW-1:0] block_rem_ff, block_rem_in;
   logic          block_good_ff, block_good_in;
   logic          byte_good_ff, byte_good_in;
   logic [WW-1:0] bad_blocks_ff, bad_blocks_in;
   logic          ok_ff, ok_in;
   logic [CW-1:0] issue_cnt_ff, issue_cnt_in;
   logic          kind_ff, kind_in;
   logic [MW-1:0] divisor_ff, divisor_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_delivered_ff, rsp_delivered_in;
   logic [WW-1:0] rsp_count_ff, rsp_count_in;

   logic [WW-1:0] draw_word;
   logic          issue;
   logic          pipe_valid;
   logic          pipe_zero;
   logic          pipe_busy;
   logic [LW-1:0] split_len;
   logic [RW-1:0] split_rem;
   logic [GW-1:0] mark_mod;
   logic [MW-1:0] mark_div;
   logic [MW-1:0] flip_div;
   logic          next_byte_good;

   assign draw_word = xorshift(random_ff);
   assign issue     = (issue_cnt_ff != '0);

   blci_modpipe u_modpipe (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (issue),
      .in_dividend (draw_word),
      .divisor     (divisor_ff),
      .out_valid   (pipe_valid),
      .out_zero    (pipe_zero),
      .busy        (pipe_busy)
   );

   assign split_len = len_ff - LW'(block_rem_ff);
   assign split_rem = (PW'(split_len) >= PW'(blci_pkg::BLOCK_SIZE)) ? '0
                    : RW'(blci_pkg::BLOCK_SIZE) - RW'(split_len);
   assign mark_mod  = block_good_ff ? good_mod_ff : bad_mod_ff;
   assign mark_div  = (mark_mod == '0) ? MW'(1) : MW'(mark_mod);
   assign flip_div  = (flip_mod_ff == '0) ? MW'(1) : flip_mod_ff;
   assign next_byte_good = pipe_zero ? !byte_good_ff : byte_good_ff;

   always_comb begin
      good_mod_in      = good_mod_ff;
      bad_mod_in       = bad_mod_ff;
      flip_mod_in      = flip_mod_ff;
      random_in        = random_ff;
      len_in           = len_ff;
      block_rem_in     = block_rem_ff;
      block_good_in    = block_good_ff;
      byte_good_in     = byte_good_ff;
      bad_blocks_in    = bad_blocks_ff;
      ok_in            = ok_ff;
      issue_cnt_in     = issue_cnt_ff;
      kind_in          = kind_ff;
      divisor_in       = divisor_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_delivered_in = rsp_delivered_ff;
      rsp_count_in     = rsp_count_ff;

      // advance the generator once per issued draw
      if (issue) begin
         issue_cnt_in = issue_cnt_ff - CW'(1);
         random_in    = draw_word;
      end

      if (csr_valid) begin
         case (csr_index)
            blci_pkg::CSR_GOOD_MODULUS: good_mod_in = csr_data[GW-1:0];
            blci_pkg::CSR_BAD_MODULUS:  bad_mod_in  = csr_data[GW-1:0];
            blci_pkg::CSR_FLIP_MODULUS: flip_mod_in = csr_data[MW-1:0];
            blci_pkg::CSR_PRNG_SEED: begin
               random_in = (csr_data == '0) ? blci_pkg::SEED_RESET : WW'(csr_data);
            end
            default: ;
         endcase
      end

      if (cmd.capture) begin
         len_in = req_packet_length;
         ok_in  = 1'b1;
      end
      if (cmd.fail) begin
         ok_in = 1'b0;
      end
      if (cmd.consume) begin
         block_rem_in = block_rem_ff - RW'(len_ff);
      end
      if (cmd.split) begin
         len_in       = split_len;
         block_rem_in = split_rem;
      end
      if (cmd.start_rem) begin
         issue_cnt_in = CW'(block_rem_ff);
         kind_in      = blci_pkg::KIND_FLIP;
         divisor_in   = flip_div;
      end
      if (cmd.start_len) begin
         issue_cnt_in = CW'(len_ff);
         kind_in      = blci_pkg::KIND_FLIP;
         divisor_in   = flip_div;
      end
      if (cmd.start_mark) begin
         issue_cnt_in = CW'(1);
         kind_in      = blci_pkg::KIND_MARK;
         divisor_in   = mark_div;
      end

      // retire one draw
      if (pipe_valid) begin
         if (kind_ff == blci_pkg::KIND_MARK) begin
            block_good_in = !pipe_zero;
            if (pipe_zero) begin
               bad_blocks_in = bad_blocks_ff + WW'(1);
            end
         end else begin
            byte_good_in = next_byte_good;
            if (!next_byte_good) begin
               ok_in = 1'b0;
            end
         end
      end

      if (cmd.respond) begin
         rsp_valid_in     = 1'b1;
         rsp_delivered_in = ok_ff;
         rsp_count_in     = bad_blocks_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         good_mod_ff   <= blci_pkg::GOOD_MOD_RESET;
         bad_mod_ff    <= blci_pkg::BAD_MOD_RESET;
         flip_mod_ff   <= blci_pkg::FLIP_MOD_RESET;
         random_ff     <= blci_pkg::SEED_RESET;
         block_rem_ff  <= '0;
         block_good_ff <= 1'b1;
         byte_good_ff  <= 1'b1;
         bad_blocks_ff <= '0;
         issue_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         good_mod_ff   <= good_mod_in;
         bad_mod_ff    <= bad_mod_in;
         flip_mod_ff   <= flip_mod_in;
         random_ff     <= random_in;
         block_rem_ff  <= block_rem_in;
         block_good_ff <= block_good_in;
         byte_good_ff  <= byte_good_in;
         bad_blocks_ff <= bad_blocks_in;
         issue_cnt_ff  <= issue_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff           <= len_in;
      ok_ff            <= ok_in;
      kind_ff          <= kind_in;
      divisor_ff       <= divisor_in;
      rsp_delivered_ff <= rsp_delivered_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign status.len_zero   = (len_ff == '0);
   assign status.len_gt_rem = (PW'(len_ff) > PW'(block_rem_ff));
   assign status.rem_zero   = (block_rem_ff == '0);
   assign status.block_good = block_good_ff;
   assign status.ok         = ok_ff;
   assign status.busy       = issue | pipe_busy;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_delivered       = rsp_delivered_ff;
   assign rsp_bad_block_count = rsp_count_ff;

   `BLCI_ASSERT(a_start_when_idle, clock, reset, (cmd.start_rem || cmd.start_len || cmd.start_mark) |-> !(issue || pipe_busy))
   `BLCI_ASSERT(a_no_rsp_overwrite, clock, reset, cmd.respond |-> (!rsp_valid_ff || rsp_ready))
   `BLCI_ASSERT(a_bad_count_steps, clock, reset, (!$past(reset) && !$stable(bad_blocks_ff)) |-> (bad_blocks_ff == $past(bad_blocks_ff) + WW'(1)))

endmodule

// ----- rtl/blci_ctrl.sv -----
// Injector controller: sequences length check, old-block judging, block mark
// draw, new-block judging and the response. Depends on blci_pkg, assert_macros.svh.
`include "assert_macros.svh"

module blci_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  blci_pkg::status_type status,
   output blci_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_DECIDE     = 3'd1;
   localparam logic [2:0] ST_OLD_WAIT   = 3'd2;
   localparam logic [2:0] ST_SPLIT      = 3'd3;
   localparam logic [2:0] ST_MARK_WAIT  = 3'd4;
   localparam logic [2:0] ST_JUDGE_WAIT = 3'd5;
   localparam logic [2:0] ST_DONE       = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.len_zero) begin
               cmd.fail = 1'b1;
               state_in = ST_DONE;
            end else if (status.len_gt_rem) begin
               if (!status.rem_zero && !status.block_good) begin
                  cmd.start_rem = 1'b1;
                  state_in      = ST_OLD_WAIT;
               end else begin
                  state_in = ST_SPLIT;
               end
            end else begin
               cmd.consume = 1'b1;
               if (!status.block_good) begin
                  cmd.start_len = 1'b1;
                  state_in      = ST_JUDGE_WAIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_OLD_WAIT: begin
            if (!status.busy) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split      = 1'b1;
            cmd.start_mark = 1'b1;
            state_in       = ST_MARK_WAIT;
         end
         ST_MARK_WAIT: begin
            if (!status.busy) begin
               if (!status.block_good && status.ok) begin
                  cmd.start_len = 1'b1;
                  state_in      = ST_JUDGE_WAIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_JUDGE_WAIT: begin
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BLCI_ASSERT(a_one_start, clock, reset, $onehot0({cmd.start_rem, cmd.start_len, cmd.start_mark}))
   `BLCI_ASSERT(a_capture_then_decide, clock, reset, cmd.capture |=> (state_ff == ST_DECIDE))

endmodule

// ----- rtl/burst_loss_channel_injector.sv -----
// Burst loss channel injector top level: controller plus datapath.
// Depends on blci_pkg, blci_ctrl, blci_datapath (and blci_modpipe below it).
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_packet_length
//   rsp      out        rsp_valid/rsp_ready    rsp_delivered, rsp_bad_block_count
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One word at a time. A packet in a good block passes from accept through DECIDE
// and DONE back to IDLE; each judged run of bytes and each block start waits for
// the 32-stage remainder pipeline to drain before the next step.
// Reset is synchronous and active high; no clearing pass is needed.
// A result held in the rsp register stalls only the final step of the next word.
module burst_loss_channel_injector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [blci_pkg::LEN_WIDTH-1:0]       req_packet_length,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_delivered,
   output logic [blci_pkg::WORD_WIDTH-1:0]      rsp_bad_block_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [blci_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [blci_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   blci_pkg::cmd_type    cmd;
   blci_pkg::status_type status;

   blci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   blci_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_packet_length   (req_packet_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_delivered       (rsp_delivered),
      .rsp_bad_block_count (rsp_bad_block_count)
   );

endmodule
